// File: rtl/core/rwep_pkg.sv
package rwep_pkg;

	localparam int WORD_BITS = 32;
	localparam int FRAC_BITS = 16;

	// derived widths
	localparam int SQ_W    = 2 * WORD_BITS;                 // squares
	localparam int PR_W    = 4 * WORD_BITS;                 // products of squares
	localparam int SUM_W   = PR_W + 1;                      // ea^2*b^2 + a^2*eb^2
	localparam int ROOT_W  = 2 * WORD_BITS + FRAC_BITS + 1; // sqrt(sum << 2F)
	localparam int RAD_W   = 2 * ROOT_W;                    // radicand, even width
	localparam int SREM_W  = ROOT_W + 2;                    // sqrt remainder
	localparam int EDIV_W  = ((ROOT_W > 3 * WORD_BITS) ? ROOT_W : 3 * WORD_BITS) + 1;
	localparam int RDIV_W  = 2 * WORD_BITS + FRAC_BITS + 1;
	localparam int FRONT   = 5;
	localparam int NST     = FRONT + ROOT_W + WORD_BITS;

	typedef logic signed [WORD_BITS-1:0] sword_t;
	typedef logic [WORD_BITS-1:0] uword_t;

	localparam uword_t NEG_LIM = {1'b1, {(WORD_BITS-1){1'b0}}};
	localparam uword_t POS_LIM = {1'b0, {(WORD_BITS-1){1'b1}}};

	typedef struct packed {
		uword_t am;
		uword_t bm;
		logic   neg;
		logic   zero;
		logic   zb;
	} side_t;

	typedef struct packed {
		sword_t value;
		uword_t error;
		logic   zero_den;
		logic   sat;
	} result_t;

endpackage

// File: rtl/core/ratio_with_error_propagation.sv
// Ratio of two bins with Gaussian error propagation, fully pipelined.
// Pipeline depth is set by the one-bit-per-stage square root and the one-bit-per-stage dividers.
// Throughput: one transaction per cycle while the skid entry is empty; a two-entry output register and skid keep
//   item_ready free of any combinational path from result_ready.
// Reset (arst_n, async, active low) clears only valid bits; payload is not reset.
module ratio_with_error_propagation (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_ready,
	input  rwep_pkg::sword_t numerator_value,
	input  rwep_pkg::uword_t numerator_error,
	input  rwep_pkg::sword_t denominator_value,
	input  rwep_pkg::uword_t denominator_error,
	output logic             result_valid,
	input  logic             result_ready,
	output rwep_pkg::sword_t ratio_value,
	output rwep_pkg::uword_t ratio_error,
	output logic             zero_denominator,
	output logic             saturated
);
	import rwep_pkg::*;

	// global advance: pipeline moves whenever the skid entry is empty
	logic en;
	logic skid_vld_q;
	logic [NST:1] vld_s;

	assign en = !skid_vld_q;
	assign item_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[NST-1:1], item_valid};
		end
	end

	// ---------------- stage 1: magnitudes and special cases ----------------
	logic   a_neg, b_neg;
	uword_t a_mag, b_mag;
	side_t  side_s1;
	uword_t ea_s1, eb_s1;

	assign a_neg = numerator_value[WORD_BITS-1];
	assign b_neg = denominator_value[WORD_BITS-1];
	assign a_mag = a_neg ? uword_t'(0) - uword_t'(numerator_value) : uword_t'(numerator_value);
	assign b_mag = b_neg ? uword_t'(0) - uword_t'(denominator_value)
	                     : uword_t'(denominator_value);

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1.am   <= a_mag;
			side_s1.bm   <= b_mag;
			side_s1.neg  <= a_neg ^ b_neg;
			side_s1.zero <= (a_mag == '0) || (b_mag == '0);
			side_s1.zb   <= (b_mag == '0);
			ea_s1        <= numerator_error;
			eb_s1        <= denominator_error;
		end
	end

	// ---------------- stage 2: four squares ----------------
	side_t            side_s2;
	logic [SQ_W-1:0]  b2_s2, ea2_s2, am2_s2, eb2_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			side_s2 <= side_s1;
			b2_s2   <= SQ_W'(side_s1.bm) * SQ_W'(side_s1.bm);
			ea2_s2  <= SQ_W'(ea_s1) * SQ_W'(ea_s1);
			am2_s2  <= SQ_W'(side_s1.am) * SQ_W'(side_s1.am);
			eb2_s2  <= SQ_W'(eb_s1) * SQ_W'(eb_s1);
		end
	end

	// ---------------- stage 3: partial products of ea^2*b^2 and a^2*eb^2 ----------------
	side_t           side_s3;
	logic [SQ_W-1:0] b2_s3;
	logic [SQ_W-1:0] p1hh_s3, p1hl_s3, p1lh_s3, p1ll_s3;
	logic [SQ_W-1:0] p2hh_s3, p2hl_s3, p2lh_s3, p2ll_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			side_s3 <= side_s2;
			b2_s3   <= b2_s2;
			p1hh_s3 <= SQ_W'(ea2_s2[SQ_W-1:WORD_BITS]) * SQ_W'(b2_s2[SQ_W-1:WORD_BITS]);
			p1hl_s3 <= SQ_W'(ea2_s2[SQ_W-1:WORD_BITS]) * SQ_W'(b2_s2[WORD_BITS-1:0]);
			p1lh_s3 <= SQ_W'(ea2_s2[WORD_BITS-1:0]) * SQ_W'(b2_s2[SQ_W-1:WORD_BITS]);
			p1ll_s3 <= SQ_W'(ea2_s2[WORD_BITS-1:0]) * SQ_W'(b2_s2[WORD_BITS-1:0]);
			p2hh_s3 <= SQ_W'(am2_s2[SQ_W-1:WORD_BITS]) * SQ_W'(eb2_s2[SQ_W-1:WORD_BITS]);
			p2hl_s3 <= SQ_W'(am2_s2[SQ_W-1:WORD_BITS]) * SQ_W'(eb2_s2[WORD_BITS-1:0]);
			p2lh_s3 <= SQ_W'(am2_s2[WORD_BITS-1:0]) * SQ_W'(eb2_s2[SQ_W-1:WORD_BITS]);
			p2ll_s3 <= SQ_W'(am2_s2[WORD_BITS-1:0]) * SQ_W'(eb2_s2[WORD_BITS-1:0]);
		end
	end

	// ---------------- stage 4: combine partial products ----------------
	side_t           side_s4;
	logic [SQ_W-1:0] b2_s4;
	logic [PR_W-1:0] t1_s4, t2_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			side_s4 <= side_s3;
			b2_s4   <= b2_s3;
			t1_s4   <= (PR_W'(p1hh_s3) << SQ_W)
			         + ((PR_W'(p1hl_s3) + PR_W'(p1lh_s3)) << WORD_BITS)
			         + PR_W'(p1ll_s3);
			t2_s4   <= (PR_W'(p2hh_s3) << SQ_W)
			         + ((PR_W'(p2hl_s3) + PR_W'(p2lh_s3)) << WORD_BITS)
			         + PR_W'(p2ll_s3);
		end
	end

	// ---------------- stage 5: S = ea^2*b^2 + a^2*eb^2 ----------------
	side_t            side_s5;
	logic [SQ_W-1:0]  b2_s5;
	logic [SUM_W-1:0] sum_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			side_s5 <= side_s4;
			b2_s5   <= b2_s4;
			sum_s5  <= SUM_W'(t1_s4) + SUM_W'(t2_s4);
		end
	end

	// ---------------- square root of S << 2F, one root bit per stage ----------------
	side_t             sq_side_s [ROOT_W];
	logic [SQ_W-1:0]   sq_b2_s   [ROOT_W];
	logic [SREM_W-1:0] sq_rem_s  [ROOT_W];
	logic [ROOT_W-1:0] sq_root_s [ROOT_W];
	logic [RAD_W-1:0]  sq_rad_s  [ROOT_W];

	for (genvar i = 0; i < ROOT_W; i++) begin : g_sqrt
		side_t             p_side;
		logic [SQ_W-1:0]   p_b2;
		logic [SREM_W-1:0] p_rem, r2, trial;
		logic [ROOT_W-1:0] p_root;
		logic [RAD_W-1:0]  p_rad;
		logic              ge;

		if (i == 0) begin : g_first
			assign p_side = side_s5;
			assign p_b2   = b2_s5;
			assign p_rem  = '0;
			assign p_root = '0;
			assign p_rad  = RAD_W'(sum_s5) << (2 * FRAC_BITS);
		end else begin : g_next
			assign p_side = sq_side_s[i-1];
			assign p_b2   = sq_b2_s[i-1];
			assign p_rem  = sq_rem_s[i-1];
			assign p_root = sq_root_s[i-1];
			assign p_rad  = sq_rad_s[i-1];
		end

		// bring down two radicand bits, try root*4+1
		assign r2    = {p_rem[SREM_W-3:0], p_rad[RAD_W-1 -: 2]};
		assign trial = {p_root, 2'b01};
		assign ge    = (r2 >= trial);

		always_ff @(posedge clk) begin
			if (en) begin
				sq_side_s[i] <= p_side;
				sq_b2_s[i]   <= p_b2;
				sq_rem_s[i]  <= ge ? r2 - trial : r2;
				sq_root_s[i] <= {p_root[ROOT_W-2:0], ge};
				sq_rad_s[i]  <= p_rad << 2;
			end
		end
	end

	// ---------------- both divisions, one quotient bit per stage ----------------
	// error:  floor(root / b^2), overflow when root >= b^2 << WORD_BITS
	// ratio:  floor(|a| << F / |b|), overflow when quotient >= 2^WORD_BITS
	side_t             dv_side_s [WORD_BITS];
	logic [SQ_W-1:0]   dv_b2_s   [WORD_BITS];
	logic [EDIV_W-1:0] dv_erem_s [WORD_BITS];
	uword_t            dv_eq_s   [WORD_BITS];
	logic              dv_eovf_s [WORD_BITS];
	logic [RDIV_W-1:0] dv_rrem_s [WORD_BITS];
	uword_t            dv_rq_s   [WORD_BITS];
	logic              dv_rovf_s [WORD_BITS];

	for (genvar j = 0; j < WORD_BITS; j++) begin : g_div
		side_t             p_side;
		logic [SQ_W-1:0]   p_b2;
		logic [EDIV_W-1:0] p_erem, ed;
		uword_t            p_eq, p_rq;
		logic              p_eovf, p_rovf, ege, rge;
		logic [RDIV_W-1:0] p_rrem, rd;

		if (j == 0) begin : g_first
			assign p_side = sq_side_s[ROOT_W-1];
			assign p_b2   = sq_b2_s[ROOT_W-1];
			assign p_erem = EDIV_W'(sq_root_s[ROOT_W-1]);
			assign p_eq   = '0;
			assign p_eovf = (EDIV_W'(sq_root_s[ROOT_W-1]) >= (EDIV_W'(p_b2) << WORD_BITS));
			assign p_rrem = RDIV_W'(p_side.am) << FRAC_BITS;
			assign p_rq   = '0;
			assign p_rovf = ((RDIV_W'(p_side.am) << FRAC_BITS)
			                 >= (RDIV_W'(p_side.bm) << WORD_BITS));
		end else begin : g_next
			assign p_side = dv_side_s[j-1];
			assign p_b2   = dv_b2_s[j-1];
			assign p_erem = dv_erem_s[j-1];
			assign p_eq   = dv_eq_s[j-1];
			assign p_eovf = dv_eovf_s[j-1];
			assign p_rrem = dv_rrem_s[j-1];
			assign p_rq   = dv_rq_s[j-1];
			assign p_rovf = dv_rovf_s[j-1];
		end

		assign ed  = EDIV_W'(p_b2) << (WORD_BITS - 1 - j);
		assign ege = (p_erem >= ed);
		assign rd  = RDIV_W'(p_side.bm) << (WORD_BITS - 1 - j);
		assign rge = (p_rrem >= rd);

		always_ff @(posedge clk) begin
			if (en) begin
				dv_side_s[j] <= p_side;
				dv_b2_s[j]   <= p_b2;
				dv_erem_s[j] <= ege ? p_erem - ed : p_erem;
				dv_eq_s[j]   <= {p_eq[WORD_BITS-2:0], ege};
				dv_eovf_s[j] <= p_eovf;
				dv_rrem_s[j] <= rge ? p_rrem - rd : p_rrem;
				dv_rq_s[j]   <= {p_rq[WORD_BITS-2:0], rge};
				dv_rovf_s[j] <= p_rovf;
			end
		end
	end

	// ---------------- result formatting: sign, clipping, special cases ----------------
	side_t   f_side;
	uword_t  f_lim, f_qm, f_q;
	logic    f_rsat, f_esat;
	result_t fin;

	assign f_side = dv_side_s[WORD_BITS-1];
	assign f_q    = dv_rq_s[WORD_BITS-1];
	assign f_lim  = f_side.neg ? NEG_LIM : POS_LIM;
	assign f_rsat = dv_rovf_s[WORD_BITS-1] || (f_q > f_lim);
	assign f_qm   = f_rsat ? f_lim : f_q;
	assign f_esat = dv_eovf_s[WORD_BITS-1];

	always_comb begin
		if (f_side.zero) begin
			fin.value    = '0;
			fin.error    = '0;
			fin.zero_den = f_side.zb;
			fin.sat      = 1'b0;
		end else begin
			fin.value    = sword_t'(f_side.neg ? uword_t'(0) - f_qm : f_qm);
			fin.error    = f_esat ? '1 : dv_eq_s[WORD_BITS-1];
			fin.zero_den = 1'b0;
			fin.sat      = f_rsat || f_esat;
		end
	end

	// ---------------- output register with skid entry ----------------
	logic    push;
	logic    outv_q;
	result_t res_q, skid_q;

	assign push = en && vld_s[NST];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outv_q     <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (result_ready) begin
				skid_vld_q <= 1'b0;
			end
		end else if (push) begin
			if (outv_q && !result_ready) begin
				skid_vld_q <= 1'b1;
			end else begin
				outv_q <= 1'b1;
			end
		end else if (result_ready) begin
			outv_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (result_ready) begin
				res_q <= skid_q;
			end
		end else if (push) begin
			if (outv_q && !result_ready) begin
				skid_q <= fin;
			end else begin
				res_q <= fin;
			end
		end
	end

	assign result_valid     = outv_q;
	assign ratio_value      = res_q.value;
	assign ratio_error      = res_q.error;
	assign zero_denominator = res_q.zero_den;
	assign saturated        = res_q.sat;

endmodule

// File: rtl/core/rwep_checker.sv
module rwep_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             item_valid,
	input logic             item_ready,
	input rwep_pkg::sword_t numerator_value,
	input rwep_pkg::uword_t numerator_error,
	input rwep_pkg::sword_t denominator_value,
	input rwep_pkg::uword_t denominator_error,
	input logic             result_valid,
	input logic             result_ready,
	input rwep_pkg::sword_t ratio_value,
	input rwep_pkg::uword_t ratio_error,
	input logic             zero_denominator,
	input logic             saturated
);
	import rwep_pkg::*;

	// a stalled result stays up
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result dropped while stalled");

	// and its payload does not move
	a_stable: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> $stable(ratio_value) && $stable(ratio_error)
			&& $stable(zero_denominator) && $stable(saturated))
		else $error("result payload changed while stalled");

	// zero denominator gives all-zero results, never clipped
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && zero_denominator |-> ratio_value == '0 && ratio_error == '0
			&& !saturated)
		else $error("zero denominator result not cleared");

	// a clipped result sits at one of the range limits
	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && saturated |-> ratio_error == '1
			|| ratio_value == sword_t'(NEG_LIM) || ratio_value == sword_t'(POS_LIM))
		else $error("saturated flag without clipped value");

endmodule

bind ratio_with_error_propagation rwep_checker u_rwep_checker (.*);
